[rtl/hsv2rgb_pkg.sv]
// Shared widths, constants and codes of the fixed-point HSV to RGB converter.
package hsv2rgb_pkg;

	// Field widths.
	localparam int ADC_WIDTH     = 12;
	localparam int CHANNEL_WIDTH = 8;

	// Parameter defaults.
	localparam int DEF_DEBOUNCE_LENGTH = 12;
	localparam int DEF_FRACTION_BITS   = 15;

	// Fixed constants of the color math.
	localparam int FULL_DEGREES    = 360;
	localparam int SEXTANT_DEGREES = 60;
	localparam int CHANNEL_MAX     = 255;

	// Register reset values.
	localparam logic [ADC_WIDTH-1:0] ADC_LOW_RESET  = 12'd120;
	localparam logic [ADC_WIDTH-1:0] ADC_HIGH_RESET = 12'd4095;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_ADC_LOW  = 1'b0,
		REG_ADC_HIGH = 1'b1
	} reg_index_t;

	// Hue sextant, named by the two hues that bound it.
	typedef enum logic [2:0] {
		SXT_RED_YELLOW    = 3'd0,
		SXT_YELLOW_GREEN  = 3'd1,
		SXT_GREEN_CYAN    = 3'd2,
		SXT_CYAN_BLUE     = 3'd3,
		SXT_BLUE_MAGENTA  = 3'd4,
		SXT_MAGENTA_RED   = 3'd5,
		SXT_NONE          = 3'd6
	} sextant_t;

endpackage

[rtl/hsv2rgb_if.sv]
// Valid/ready channel interfaces for the knob samples and the resulting color.

interface hsv2rgb_samples_if import hsv2rgb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ADC_WIDTH-1:0] hue_sample;
	logic [ADC_WIDTH-1:0] saturation_sample;
	logic [ADC_WIDTH-1:0] value_sample;
	logic                 switch_level;

	modport source (
		output valid, hue_sample, saturation_sample, value_sample, switch_level,
		input  ready
	);
	modport sink (
		input  valid, hue_sample, saturation_sample, value_sample, switch_level,
		output ready
	);
endinterface

interface hsv2rgb_color_if import hsv2rgb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CHANNEL_WIDTH-1:0] red;
	logic [CHANNEL_WIDTH-1:0] green;
	logic [CHANNEL_WIDTH-1:0] blue;
	logic                     light_on;

	modport source (
		output valid, red, green, blue, light_on,
		input  ready
	);
	modport sink (
		input  valid, red, green, blue, light_on,
		output ready
	);
endinterface

[rtl/hsv_to_rgb_fixed_point_core.sv]
// Fixed-point HSV to RGB converter core with a debounced light switch.

// The block takes one set of knob samples at a time and returns one color per set.
// Each item passes through phases set by the bit-serial restoring dividers, which
// produce one quotient bit per cycle: three lanes map the samples in parallel, then
// one lane divides the hue by sixty while a shift-add multiplier forms chroma one bit
// per cycle, and the same multiplier then forms the secondary component. A finished
// color waits in the output register, so the next samples are taken while it is still
// unclaimed. The debounce history is updated at each sample transfer; configuration
// writes take effect at once and should only be made while the block is idle.
module hsv_to_rgb_fixed_point_core
	import hsv2rgb_pkg::*;
#(
	parameter int DEBOUNCE_LENGTH = DEF_DEBOUNCE_LENGTH,
	parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [ADC_WIDTH-1:0] cfg_data,
	hsv2rgb_samples_if.sink      samples,
	hsv2rgb_color_if.source      color
);

	// Derived widths.
	localparam int DVW = FRACTION_BITS + ADC_WIDTH + 1;   // dividend shift register
	localparam int RW  = ADC_WIDTH + 1;                   // partial remainder
	localparam int VW  = FRACTION_BITS + 1;               // Q fraction 0..one
	localparam int QW  = FRACTION_BITS + 3;               // scaled hue 0..6*one
	localparam int PW  = 2 * VW;                          // multiplier product
	localparam int CW  = $clog2(DVW);                     // step counter
	localparam int XW  = VW + 1;                          // channel sum
	localparam int SW  = XW + CHANNEL_WIDTH;              // scaled channel
	localparam int DW  = 9;                               // whole degrees 0..360

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAP  = 5'b00010,
		ST_HUE  = 5'b00100,
		ST_MULX = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic [ADC_WIDTH-1:0]     adc_low_q;
	logic [ADC_WIDTH-1:0]     adc_high_q;
	logic [DEBOUNCE_LENGTH-1:0] hist_q;
	logic                     out_valid_q;

	logic [ADC_WIDTH-1:0]     den_q;
	logic                     empty_q;
	logic                     light_q;
	logic [DVW-1:0]           dv_q   [3];
	logic [RW-1:0]            rem_q  [3];
	logic [DVW-1:0]           quo_q  [3];
	logic [VW-1:0]            val_q;
	logic [VW-1:0]            chroma_q;
	logic [VW-1:0]            tri_q;
	sextant_t                 sxt_q;
	logic [VW-1:0]            mcand_q;
	logic [VW-1:0]            mpl_q;
	logic [PW-1:0]            prod_q;
	logic [CHANNEL_WIDTH-1:0] red_q;
	logic [CHANNEL_WIDTH-1:0] green_q;
	logic [CHANNEL_WIDTH-1:0] blue_q;
	logic                     light_out_q;

	logic                     in_xfer;
	logic                     out_load;
	logic                     map_last;
	logic                     hue_last;
	logic                     mulx_last;

	// Handshakes and phase ends.
	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || color.ready);
	assign map_last      = (state_q == ST_MAP) && (cnt_q == CW'(DVW - 1));
	assign hue_last      = (state_q == ST_HUE) && (cnt_q == CW'(DVW - 1));
	assign mulx_last     = (state_q == ST_MULX) && (cnt_q == CW'(VW - 1));

	// Clamp the samples into range and take their offset from the low reading.
	logic [ADC_WIDTH-1:0] raw_s [3];
	logic [ADC_WIDTH-1:0] off_s [3];
	logic [ADC_WIDTH-1:0] clamp_s;
	logic [DEBOUNCE_LENGTH:0] hist_wide;
	logic [DEBOUNCE_LENGTH-1:0] hist_n;

	always_comb begin
		raw_s[0] = samples.hue_sample;
		raw_s[1] = samples.saturation_sample;
		raw_s[2] = samples.value_sample;
		clamp_s  = '0;
		for (int i = 0; i < 3; i++) begin
			if (raw_s[i] < adc_low_q) begin
				clamp_s = adc_low_q;
			end else if (raw_s[i] > adc_high_q) begin
				clamp_s = adc_high_q;
			end else begin
				clamp_s = raw_s[i];
			end
			off_s[i] = clamp_s - adc_low_q;
		end
		hist_wide = {hist_q, samples.switch_level};
		hist_n    = hist_wide[DEBOUNCE_LENGTH-1:0];
	end

	// One restoring division step per lane; lane zero divides by sixty in the hue phase.
	logic [ADC_WIDTH-1:0] lane_den [3];
	logic [RW-1:0]        trial    [3];
	logic [RW-1:0]        rem_n    [3];
	logic [DVW-1:0]       quo_n    [3];

	always_comb begin
		lane_den[0] = (state_q == ST_HUE) ? ADC_WIDTH'(SEXTANT_DEGREES) : den_q;
		lane_den[1] = den_q;
		lane_den[2] = den_q;
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i][RW-2:0], dv_q[i][DVW-1]};
			if (trial[i] >= {1'b0, lane_den[i]}) begin
				rem_n[i] = trial[i] - {1'b0, lane_den[i]};
				quo_n[i] = {quo_q[i][DVW-2:0], 1'b1};
			end else begin
				rem_n[i] = trial[i];
				quo_n[i] = {quo_q[i][DVW-2:0], 1'b0};
			end
		end
	end

	// Shift-add multiplier step, one multiplier bit per cycle.
	logic [VW:0]   mul_sum;
	logic [PW-1:0] prod_n;
	logic          mul_step;

	always_comb begin
		mul_sum  = {1'b0, prod_q[PW-1:VW]} + (mpl_q[0] ? {1'b0, mcand_q} : '0);
		prod_n   = {mul_sum, prod_q[VW-1:1]};
		mul_step = ((state_q == ST_HUE) && (cnt_q < CW'(VW))) || (state_q == ST_MULX);
	end

	// Mapped samples at the end of the mapping phase.
	logic [DW-1:0] deg_n;
	logic [VW-1:0] sat_n;
	logic [VW-1:0] val_n;

	always_comb begin
		deg_n = empty_q ? '0 : quo_n[0][DW-1:0];
		sat_n = empty_q ? '0 : quo_n[1][VW-1:0];
		val_n = empty_q ? '0 : quo_n[2][VW-1:0];
	end

	// Sextant and triangle weight from the scaled hue.
	logic [QW-1:0] hp;
	logic [VW-1:0] hmod;
	logic [VW-1:0] one_v;
	logic [VW-1:0] hdist;
	logic [VW-1:0] tri_n;
	sextant_t      sxt_n;

	always_comb begin
		hp    = quo_n[0][QW-1:0];
		one_v = VW'(1) << FRACTION_BITS;
		hmod  = hp[VW-1:0];
		hdist = (hmod >= one_v) ? (hmod - one_v) : (one_v - hmod);
		tri_n = one_v - hdist;
		if (hp <= (QW'(1) << FRACTION_BITS)) begin
			sxt_n = SXT_RED_YELLOW;
		end else if (hp <= (QW'(2) << FRACTION_BITS)) begin
			sxt_n = SXT_YELLOW_GREEN;
		end else if (hp <= (QW'(3) << FRACTION_BITS)) begin
			sxt_n = SXT_GREEN_CYAN;
		end else if (hp <= (QW'(4) << FRACTION_BITS)) begin
			sxt_n = SXT_CYAN_BLUE;
		end else if (hp <= (QW'(5) << FRACTION_BITS)) begin
			sxt_n = SXT_BLUE_MAGENTA;
		end else if (hp <= (QW'(6) << FRACTION_BITS)) begin
			sxt_n = SXT_MAGENTA_RED;
		end else begin
			sxt_n = SXT_NONE;
		end
	end

	// Channel order by sextant, offset by m and scaled to eight bits.
	logic [VW-1:0]            xv;
	logic [VW-1:0]            m_v;
	logic [VW-1:0]            base   [3];
	logic [XW-1:0]            chan   [3];
	logic [SW-1:0]            scaled [3];
	logic [CHANNEL_WIDTH-1:0] chan8  [3];

	always_comb begin
		xv      = prod_q[PW-2:FRACTION_BITS];
		m_v     = val_q - chroma_q;
		base[0] = '0;
		base[1] = '0;
		base[2] = '0;
		case (sxt_q)
			SXT_RED_YELLOW: begin
				base[0] = chroma_q;
				base[1] = xv;
			end
			SXT_YELLOW_GREEN: begin
				base[0] = xv;
				base[1] = chroma_q;
			end
			SXT_GREEN_CYAN: begin
				base[1] = chroma_q;
				base[2] = xv;
			end
			SXT_CYAN_BLUE: begin
				base[1] = xv;
				base[2] = chroma_q;
			end
			SXT_BLUE_MAGENTA: begin
				base[0] = xv;
				base[2] = chroma_q;
			end
			SXT_MAGENTA_RED: begin
				base[0] = chroma_q;
				base[2] = xv;
			end
			default: begin
				base[0] = '0;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			chan[i]   = XW'(base[i]) + XW'(m_v);
			scaled[i] = (({chan[i], {CHANNEL_WIDTH{1'b0}}} - SW'(chan[i])) >> FRACTION_BITS);
			if (scaled[i] > SW'(CHANNEL_MAX)) begin
				chan8[i] = CHANNEL_WIDTH'(CHANNEL_MAX);
			end else begin
				chan8[i] = scaled[i][CHANNEL_WIDTH-1:0];
			end
		end
	end

	// Control state: sequencer, counter, registers, debounce history, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			adc_low_q   <= ADC_LOW_RESET;
			adc_high_q  <= ADC_HIGH_RESET;
			hist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ADC_LOW:  adc_low_q  <= cfg_data;
					REG_ADC_HIGH: adc_high_q <= cfg_data;
					default:      adc_low_q  <= adc_low_q;
				endcase
			end
			if (in_xfer) begin
				hist_q <= hist_n;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (color.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					cnt_q <= cnt_q + 1'b1;
					if (map_last) begin
						cnt_q   <= '0;
						state_q <= ST_HUE;
					end
				end
				ST_HUE: begin
					cnt_q <= cnt_q + 1'b1;
					if (hue_last) begin
						cnt_q   <= '0;
						state_q <= ST_MULX;
					end
				end
				ST_MULX: begin
					cnt_q <= cnt_q + 1'b1;
					if (mulx_last) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: divider lanes, multiplier and intermediate results.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			den_q    <= adc_high_q - adc_low_q;
			empty_q  <= (adc_high_q <= adc_low_q);
			light_q  <= &hist_n;
			dv_q[0]  <= DVW'(off_s[0]) * DVW'(FULL_DEGREES);
			dv_q[1]  <= DVW'(off_s[1]) << FRACTION_BITS;
			dv_q[2]  <= DVW'(off_s[2]) << FRACTION_BITS;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (map_last) begin
			val_q    <= val_n;
			dv_q[0]  <= DVW'(deg_n) << FRACTION_BITS;
			rem_q[0] <= '0;
			quo_q[0] <= '0;
			mcand_q  <= val_n;
			mpl_q    <= sat_n;
			prod_q   <= '0;
		end else if ((state_q == ST_MAP) || (state_q == ST_HUE)) begin
			for (int i = 0; i < 3; i++) begin
				dv_q[i]  <= dv_q[i] << 1;
				rem_q[i] <= rem_n[i];
				quo_q[i] <= quo_n[i];
			end
		end
		if (hue_last) begin
			chroma_q <= prod_q[PW-2:FRACTION_BITS];
			tri_q    <= tri_n;
			sxt_q    <= sxt_n;
			mcand_q  <= prod_q[PW-2:FRACTION_BITS];
			mpl_q    <= tri_n;
			prod_q   <= '0;
		end else if (mul_step && !map_last) begin
			prod_q <= prod_n;
			mpl_q  <= mpl_q >> 1;
		end
		if (out_load) begin
			red_q       <= chan8[0];
			green_q     <= chan8[1];
			blue_q      <= chan8[2];
			light_out_q <= light_q;
		end
	end

	// Output channel.
	assign color.valid    = out_valid_q;
	assign color.red      = red_q;
	assign color.green    = green_q;
	assign color.blue     = blue_q;
	assign color.light_on = light_out_q;

	// A sample transfer always starts the mapping phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MAP))
	else $error("sample transfer did not start the mapping phase");

	// A color leaving the sequencer always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == ST_IDLE)))
	else $error("finished color was not registered");

	// An empty converter range forces value to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(map_last && empty_q) |=> (val_q == '0))
	else $error("empty range did not zero the value");

	// Chroma never exceeds value, so m cannot wrap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULX) |-> (chroma_q <= val_q))
	else $error("chroma above value");

	// The triangle weight stays within one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULX) |-> (tri_q <= (VW'(1) << FRACTION_BITS)))
	else $error("triangle weight above one");

endmodule

[test/tb.sv]
// Self-checking testbench of the fixed-point HSV to RGB converter core.
module tb;
	import hsv2rgb_pkg::*;

	localparam int FRAC            = DEF_FRACTION_BITS;
	localparam int HISTORY_LEN     = DEF_DEBOUNCE_LENGTH;
	localparam int SAMPLE_MAX      = (1 << ADC_WIDTH) - 1;
	localparam longint unsigned UNIT = 64'd1 << FRAC;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int DRAIN_PHASE     = 3;
	localparam int HOLDOFF_PHASE   = 6;
	localparam int HOLDOFF_CYCLES  = 400;
	localparam int STALL_LIMIT     = 3000;
	localparam int DRAIN_TAIL      = 100;

	typedef struct packed {
		logic [ADC_WIDTH-1:0] hue;
		logic [ADC_WIDTH-1:0] sat;
		logic [ADC_WIDTH-1:0] val;
		logic                 sw;
	} knob_set_t;

	typedef struct packed {
		logic [CHANNEL_WIDTH-1:0] red;
		logic [CHANNEL_WIDTH-1:0] green;
		logic [CHANNEL_WIDTH-1:0] blue;
		logic                     light;
	} color_t;

	typedef struct packed {
		logic   typed;
		color_t want;
	} hand_check_t;

	typedef struct packed {
		knob_set_t knobs;
		logic      typed;
		color_t    want;
	} directed_row_t;

	typedef enum int {
		FLOW_FREE,
		FLOW_COIN,
		FLOW_MOSTLY,
		FLOW_STALLS
	} flow_mode_t;

	// Directed rows: hue, saturation, value, switch | typed | red, green, blue, light.
	// The switch is low first and then high twelve times, so the light comes on at row 13.
	localparam directed_row_t DIRECTED_ROWS [21] = '{
		{12'd0,    12'd0,    12'd0,    1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
		{12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, 8'd255, 8'd0,   8'd0,   1'b0},
		{12'd0,    12'd4095, 12'd4095, 1'b1, 1'b1, 8'd255, 8'd0,   8'd0,   1'b0},
		{12'd0,    12'd0,    12'd4095, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
		{12'd4095, 12'd0,    12'd4095, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
		{12'd2000, 12'd4095, 12'd0,    1'b1, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0},
		{12'd119,  12'd4095, 12'd4095, 1'b1, 1'b1, 8'd255, 8'd0,   8'd0,   1'b0},
		{12'd120,  12'd120,  12'd4095, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
		{12'd783,  12'd4095, 12'd4095, 1'b1, 1'b0, 25'd0},
		{12'd1445, 12'd4095, 12'd4095, 1'b1, 1'b0, 25'd0},
		{12'd2108, 12'd4095, 12'd4095, 1'b1, 1'b0, 25'd0},
		{12'd2770, 12'd4095, 12'd4095, 1'b1, 1'b0, 25'd0},
		{12'd3433, 12'd4095, 12'd4095, 1'b1, 1'b0, 25'd0},
		{12'd4094, 12'd4095, 12'd4095, 1'b0, 1'b0, 25'd0},
		{12'hAAA,  12'h555,  12'hAAA,  1'b1, 1'b0, 25'd0},
		{12'h555,  12'hAAA,  12'h555,  1'b1, 1'b0, 25'd0},
		{12'h800,  12'h7FF,  12'h800,  1'b0, 1'b0, 25'd0},
		{12'h7FF,  12'h800,  12'hFFF,  1'b1, 1'b0, 25'd0},
		{12'd1000, 12'd2000, 12'd3000, 1'b0, 1'b0, 25'd0},
		{12'd3000, 12'd2048, 12'd1024, 1'b1, 1'b0, 25'd0},
		{12'd2500, 12'd4095, 12'd2048, 1'b0, 1'b0, 25'd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [ADC_WIDTH-1:0] cfg_data;

	hsv2rgb_samples_if samples_ch ();
	hsv2rgb_color_if   color_ch ();

	hsv_to_rgb_fixed_point_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.color     (color_ch)
	);

	// Predictor state: the converter range and the debounce history.
	logic [ADC_WIDTH-1:0]   range_low = ADC_LOW_RESET;
	logic [ADC_WIDTH-1:0]   range_high = ADC_HIGH_RESET;
	logic [HISTORY_LEN-1:0] switch_history = '0;

	color_t      pending_colors [$];
	hand_check_t hand_checked [$];

	int   failures = 0;
	int   items_in = 0;
	int   colors_out = 0;
	int   light_hits = 0;
	int   holdoff_requests = 0;
	int   burst_left = 0;
	int   sw_run_left = 0;
	logic sw_level = 1'b0;
	bit   offering = 1'b0;
	bit   steady_flow = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Clamp a raw sample into the converter range and scale it to 0..full, truncating.
	function automatic longint unsigned map_knob(logic [ADC_WIDTH-1:0] raw,
			longint unsigned full);
		longint unsigned s;
		longint unsigned lo;
		longint unsigned hi;
		lo = range_low;
		hi = range_high;
		if (hi <= lo)
			return 0;
		s = raw;
		if (s < lo)
			s = lo;
		if (s > hi)
			s = hi;
		return ((s - lo) * full) / (hi - lo);
	endfunction

	function automatic logic [CHANNEL_WIDTH-1:0] to_level(longint unsigned x);
		longint unsigned lvl;
		lvl = (x * CHANNEL_MAX) >> FRAC;
		if (lvl > CHANNEL_MAX)
			lvl = CHANNEL_MAX;
		return lvl[CHANNEL_WIDTH-1:0];
	endfunction

	// Color expected for one knob set, given the history after its switch sample.
	function automatic color_t predict_color(knob_set_t k, logic [HISTORY_LEN-1:0] hist);
		longint unsigned deg, sat, val, hp, chroma, hmod, fold, wave, xv, floor_level;
		longint unsigned r, g, b;
		sextant_t        sxt;
		color_t          c;
		deg = map_knob(k.hue, FULL_DEGREES);
		sat = map_knob(k.sat, UNIT);
		val = map_knob(k.val, UNIT);
		hp = (deg << FRAC) / SEXTANT_DEGREES;
		chroma = (val * sat) >> FRAC;
		hmod = hp % (2 * UNIT);
		fold = (hmod >= UNIT) ? hmod - UNIT : UNIT - hmod;
		wave = UNIT - fold;
		xv = (chroma * wave) >> FRAC;
		floor_level = val - chroma;

		// A hue exactly on a boundary belongs to the lower sextant.
		if (hp <= UNIT)
			sxt = SXT_RED_YELLOW;
		else if (hp <= 2 * UNIT)
			sxt = SXT_YELLOW_GREEN;
		else if (hp <= 3 * UNIT)
			sxt = SXT_GREEN_CYAN;
		else if (hp <= 4 * UNIT)
			sxt = SXT_CYAN_BLUE;
		else if (hp <= 5 * UNIT)
			sxt = SXT_BLUE_MAGENTA;
		else if (hp <= 6 * UNIT)
			sxt = SXT_MAGENTA_RED;
		else
			sxt = SXT_NONE;

		r = 0;
		g = 0;
		b = 0;
		case (sxt)
			SXT_RED_YELLOW: begin
				r = chroma;
				g = xv;
			end
			SXT_YELLOW_GREEN: begin
				r = xv;
				g = chroma;
			end
			SXT_GREEN_CYAN: begin
				g = chroma;
				b = xv;
			end
			SXT_CYAN_BLUE: begin
				g = xv;
				b = chroma;
			end
			SXT_BLUE_MAGENTA: begin
				r = xv;
				b = chroma;
			end
			SXT_MAGENTA_RED: begin
				r = chroma;
				b = xv;
			end
			default: begin
			end
		endcase

		c.red = to_level(r + floor_level);
		c.green = to_level(g + floor_level);
		c.blue = to_level(b + floor_level);
		c.light = &hist;
		return c;
	endfunction

	// Samples favor the rails and the edges of the current range.
	function automatic logic [ADC_WIDTH-1:0] pick_sample(int unsigned lo, int unsigned hi);
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = SAMPLE_MAX;
			2: v = lo;
			3: v = hi;
			4: v = int'(lo) + int'($urandom_range(0, 6)) - 3;
			5: v = int'(hi) + int'($urandom_range(0, 6)) - 3;
			default: v = $urandom_range(0, SAMPLE_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[ADC_WIDTH-1:0];
	endfunction

	// The switch moves in runs: long closed runs that light the lamp, short open ones.
	function automatic logic next_switch();
		if (sw_run_left == 0) begin
			sw_level = ~sw_level;
			sw_run_left = sw_level ? $urandom_range(1, 30) : $urandom_range(1, 6);
		end
		sw_run_left--;
		return sw_level;
	endfunction

	// Offer one knob set, wait for its transfer, then maybe end the burst with a gap.
	task automatic send_one(knob_set_t k, logic typed, color_t want);
		int gap;
		hand_checked.push_back('{typed: typed, want: want});
		samples_ch.valid <= 1'b1;
		samples_ch.hue_sample <= k.hue;
		samples_ch.saturation_sample <= k.sat;
		samples_ch.value_sample <= k.val;
		samples_ch.switch_level <= k.sw;
		offering = 1'b1;
		do @(posedge clk); while (!samples_ch.ready);
		if (!steady_flow) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: gap = $urandom_range(0, 3);
					5, 6, 7: gap = $urandom_range(4, 40);
					default: gap = $urandom_range(41, 120);
				endcase
				if (gap > 0) begin
					samples_ch.valid <= 1'b0;
					offering = 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// Stop offering and wait until every expected color has been transferred.
	task automatic settle();
		if (offering) begin
			samples_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		do @(posedge clk); while (pending_colors.size() != 0);
	endtask

	task automatic program_range(int unsigned lo, int unsigned hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_ADC_LOW;
		cfg_data <= lo[ADC_WIDTH-1:0];
		@(posedge clk);
		cfg_index <= REG_ADC_HIGH;
		cfg_data <= hi[ADC_WIDTH-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Track register writes and predict the color of each sample transfer.
	always @(posedge clk) begin : sample_tracker
		hand_check_t hc;
		color_t      guess;
		if (arst_n && cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ADC_LOW: range_low = cfg_data;
				REG_ADC_HIGH: range_high = cfg_data;
				default: begin
				end
			endcase
		end
		if (arst_n && samples_ch.valid && samples_ch.ready) begin
			switch_history = {switch_history[HISTORY_LEN-2:0], samples_ch.switch_level};
			guess = predict_color('{hue: samples_ch.hue_sample,
				sat: samples_ch.saturation_sample, val: samples_ch.value_sample,
				sw: samples_ch.switch_level}, switch_history);
			hc = hand_checked.pop_front();
			pending_colors.push_back(hc.typed ? hc.want : guess);
			items_in++;
		end
	end

	// Compare each color transfer with the oldest expected color.
	always @(posedge clk) begin : color_checker
		color_t want;
		if (arst_n && color_ch.valid && color_ch.ready) begin
			colors_out++;
			if (pending_colors.size() == 0) begin
				$error("color transfer with no result expected");
				failures++;
			end else begin
				want = pending_colors.pop_front();
				if (color_ch.red !== want.red) begin
					$error("red: expected %0d, actual %0d", want.red, color_ch.red);
					failures++;
				end
				if (color_ch.green !== want.green) begin
					$error("green: expected %0d, actual %0d", want.green, color_ch.green);
					failures++;
				end
				if (color_ch.blue !== want.blue) begin
					$error("blue: expected %0d, actual %0d", want.blue, color_ch.blue);
					failures++;
				end
				if (color_ch.light_on !== want.light) begin
					$error("light_on: expected %0d, actual %0d", want.light,
						color_ch.light_on);
					failures++;
				end
				if (color_ch.light_on === 1'b1)
					light_hits++;
			end
		end
	end

	// End the run if nothing moves for too long.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || cfg_we || (samples_ch.valid && samples_ch.ready)
				|| (color_ch.valid && color_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles", quiet);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// The receiver changes its stall pattern in segments and serves hold-off requests.
	initial begin : color_receiver
		flow_mode_t  mode;
		int unsigned span;
		int          served;
		served = 0;
		color_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			mode = flow_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			repeat (span) begin
				if (holdoff_requests != served) begin
					served++;
					color_ch.ready <= 1'b0;
					repeat (HOLDOFF_CYCLES) @(posedge clk);
				end
				case (mode)
					FLOW_FREE: color_ch.ready <= 1'b1;
					FLOW_COIN: color_ch.ready <= 1'($urandom_range(0, 1));
					FLOW_MOSTLY: color_ch.ready <= ($urandom_range(0, 9) != 0);
					default: begin
						if ($urandom_range(0, 49) == 0) begin
							color_ch.ready <= 1'b0;
							repeat ($urandom_range(20, 150)) @(posedge clk);
						end
						color_ch.ready <= 1'b1;
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// Stimulus: reset, the directed rows, then one random phase per converter range.
	initial begin : stimulus
		int unsigned lo_list [PHASES];
		int unsigned hi_list [PHASES];
		knob_set_t   k;
		lo_list = '{0, SAMPLE_MAX, 2048, 100, 0, SAMPLE_MAX - 1, 0, 0, 0, 0, 0, ADC_LOW_RESET};
		hi_list = '{SAMPLE_MAX, 0, 2048, 3000, 1, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, 0,
			ADC_HIGH_RESET};
		for (int p = 7; p < PHASES - 1; p++) begin
			lo_list[p] = $urandom_range(0, 3000);
			hi_list[p] = $urandom_range(lo_list[p] + 1, SAMPLE_MAX);
		end

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ADC_LOW;
		cfg_data <= '0;
		samples_ch.valid <= 1'b0;
		samples_ch.hue_sample <= '0;
		samples_ch.saturation_sample <= '0;
		samples_ch.value_sample <= '0;
		samples_ch.switch_level <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_one(DIRECTED_ROWS[i].knobs, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_range(lo_list[p], hi_list[p]);
			steady_flow = (p == HOLDOFF_PHASE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Hold the receiver off while the sender keeps offering.
				if (p == HOLDOFF_PHASE && n == 10)
					holdoff_requests <= holdoff_requests + 1;
				// Let the block drain completely in the middle of a phase.
				if (p == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2)
					settle();
				k.hue = pick_sample(lo_list[p], hi_list[p]);
				k.sat = pick_sample(lo_list[p], hi_list[p]);
				k.val = pick_sample(lo_list[p], hi_list[p]);
				k.sw = next_switch();
				send_one(k, 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Converted %0d knob sets under %0d converter ranges, empty ones included.",
			items_in, PHASES + 1);
		$display("Checked %0d colors; the debounced light was on in %0d of them.",
			colors_out, light_hits);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
